>>> rtl/core/pcfc_pkg.sv
// Shared types and constants for the peer credit flow control block.
// No dependencies; used by peer_credit_flow_control.
`default_nettype none

package pcfc_pkg;

   // Number of machines in the broadcast group (2 to 32)
   localparam int MACHINES = 8;
   localparam int IDX_W    = $clog2(MACHINES);

   localparam int SELF_W   = 5;
   localparam int CNT_W    = 8;
   localparam int CSR_W    = 8;
   localparam int CSR_AW   = 2;

   // Request kinds carried on req_tuser
   typedef enum logic [1:0] {
      FUNC_BCAST  = 2'd0,
      FUNC_CREDIT = 2'd1,
      FUNC_COH    = 2'd2,
      FUNC_NONE   = 2'd3
   } func_type;

   // Register indexes on the csr port
   typedef enum logic [CSR_AW-1:0] {
      CSR_SELF_ID    = 2'd0,
      CSR_CREDIT_MAX = 2'd1,
      CSR_CREDITS_PM = 2'd2,
      CSR_SIG_PERIOD = 2'd3
   } csr_index_type;

   localparam logic [SELF_W-1:0] SELF_RESET   = 5'd0;
   localparam logic [CNT_W-1:0]  CMAX_RESET   = 8'd30;
   localparam logic [CNT_W-1:0]  CPM_RESET    = 8'd10;
   localparam logic [CNT_W-1:0]  PERIOD_RESET = 8'd8;

   // One request after the input register
   typedef struct packed {
      func_type          func;
      logic              needs_broadcast;
      logic [7:0]        peer;
      logic              status_ok;
      logic              last_in_batch;
   } req_type;

   // One result, packed as on rsp_tdata (lowest field last here)
   typedef struct packed {
      logic              ignored;
      logic              credit_signaled;
      logic [SELF_W-1:0] credit_target;
      logic              credit_send;
      logic              stalled;
      logic              granted;
   } rsp_type;

endpackage

`default_nettype wire

>>> rtl/core/peer_credit_flow_control.sv
// Peer credit flow control: broadcast grant, credit intake and credit return.
// Depends on pcfc_pkg.
//
// Usage:
//   req_* carries one request per handshake: req_tuser is the kind (broadcast
//   request, credit message, coherence message), req_tlast marks the last
//   operation of a broadcast batch. rsp_* returns exactly one result per
//   request, in order. csr_* writes the four configuration registers; write
//   self_id or credit_max only while idle, as either reloads the credit table.
//   Pipeline: a request accepted sits in the input register; its result is
//   registered in the result register when that is free, and is taken from
//   there. Throughput: one request per cycle while rsp_tready keeps up; the
//   credit table and per-peer counters are checked and updated in parallel
//   in the combinational logic between the two registers.
//   Reset (synchronous): credit_max credits for every peer, zero for self,
//   counters and batch hold cleared, registers at their defaults.
//   When rsp_tready is low the result is held; one further request waits in
//   the input register, after which req_tready falls.
`default_nettype none

module peer_credit_flow_control (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,  // [0] needs_broadcast, [8:1] peer, [9] status_ok
   input  wire logic [1:0]  req_tuser,  // [1:0] func
   input  wire logic        req_tlast,  // last_in_batch
   // result channel
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,  // [0] granted, [1] stalled, [2] credit_send,
                                        // [7:3] credit_target, [8] credit_signaled,
                                        // [9] ignored
   // configuration
   input  wire logic                        csr_we,
   input  wire logic [pcfc_pkg::CSR_AW-1:0] csr_addr,
   input  wire logic [pcfc_pkg::CSR_W-1:0]  csr_wdata
);

   localparam int M  = pcfc_pkg::MACHINES;
   localparam int IW = pcfc_pkg::IDX_W;
   localparam int SW = pcfc_pkg::SELF_W;
   localparam int CW = pcfc_pkg::CNT_W;

   // configuration
   logic [SW-1:0] self_id_ff;
   logic [CW-1:0] credit_max_ff, cpm_ff, period_ff;
   logic [SW-1:0] self_id_in;
   logic [CW-1:0] credit_max_in, cpm_in, period_in;

   // state
   logic [CW-1:0] credits_ff [M];
   logic [CW-1:0] credits_in [M];
   logic [CW-1:0] seen_ff [M];
   logic [CW-1:0] seen_in [M];
   logic [CW-1:0] phase_ff, phase_in;
   logic          hold_ff, hold_in;

   // pipeline
   logic                  s1_valid_ff, s1_valid_in;
   pcfc_pkg::req_type     s1_req_ff, s1_req_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   pcfc_pkg::rsp_type     rsp_ff, rsp_in;

   logic          out_free, s1_go;
   logic          all_credit, bad_arrival;
   logic [IW-1:0] pidx;
   logic [CW:0]   credit_sum;
   logic [CW-1:0] seen_next;
   logic [CW:0]   phase_inc;
   logic          reload;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign s1_go      = s1_valid_ff && out_free;
   assign req_tready = !s1_valid_ff || out_free;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, rsp_ff};

   assign pidx = s1_req_ff.peer[IW-1:0];

   always_comb begin
      all_credit = 1'b1;
      for (int m = 0; m < M; m++) begin
         if (self_id_ff != SW'(m) && credits_ff[m] == '0) begin
            all_credit = 1'b0;
         end
      end
   end

   assign bad_arrival = !s1_req_ff.status_ok || s1_req_ff.peer >= 8'(M)
                        || s1_req_ff.peer == {3'b000, self_id_ff};
   assign credit_sum  = {1'b0, credits_ff[pidx]} + {1'b0, cpm_ff};
   assign seen_next   = (seen_ff[pidx] == '1) ? seen_ff[pidx] : seen_ff[pidx] + 1'b1;
   assign phase_inc   = {1'b0, phase_ff} + 1'b1;

   // configuration writes
   always_comb begin
      self_id_in    = self_id_ff;
      credit_max_in = credit_max_ff;
      cpm_in        = cpm_ff;
      period_in     = period_ff;
      reload        = 1'b0;
      if (csr_we) begin
         unique case (pcfc_pkg::csr_index_type'(csr_addr))
            pcfc_pkg::CSR_SELF_ID: begin
               self_id_in = csr_wdata[SW-1:0];
               reload     = 1'b1;
            end
            pcfc_pkg::CSR_CREDIT_MAX: begin
               credit_max_in = csr_wdata;
               reload        = 1'b1;
            end
            pcfc_pkg::CSR_CREDITS_PM: cpm_in    = csr_wdata;
            pcfc_pkg::CSR_SIG_PERIOD: period_in = csr_wdata;
            default: ;
         endcase
      end
   end

   // request handling and state update
   always_comb begin
      credits_in = credits_ff;
      seen_in    = seen_ff;
      phase_in   = phase_ff;
      hold_in    = hold_ff;
      rsp_in     = rsp_ff;

      if (s1_go) begin
         rsp_in = '0;
         unique case (s1_req_ff.func)
            pcfc_pkg::FUNC_BCAST: begin
               if (s1_req_ff.needs_broadcast) begin
                  if (!hold_ff && all_credit) begin
                     for (int m = 0; m < M; m++) begin
                        if (self_id_ff != SW'(m)) begin
                           credits_in[m] = credits_ff[m] - 1'b1;
                        end
                     end
                     rsp_in.granted = 1'b1;
                  end else begin
                     rsp_in.stalled = 1'b1;
                     hold_in        = 1'b1;
                  end
               end
               // end of batch drops the hold after this request is handled
               if (s1_req_ff.last_in_batch) begin
                  hold_in = 1'b0;
               end
            end
            pcfc_pkg::FUNC_CREDIT: begin
               if (bad_arrival) begin
                  rsp_in.ignored = 1'b1;
               end else if (credit_sum > {1'b0, credit_max_ff}) begin
                  credits_in[pidx] = credit_max_ff;
               end else begin
                  credits_in[pidx] = credit_sum[CW-1:0];
               end
            end
            pcfc_pkg::FUNC_COH: begin
               if (bad_arrival) begin
                  rsp_in.ignored = 1'b1;
               end else if (seen_next >= cpm_ff) begin
                  seen_in[pidx]          = '0;
                  rsp_in.credit_send     = 1'b1;
                  rsp_in.credit_target   = s1_req_ff.peer[SW-1:0];
                  rsp_in.credit_signaled = (phase_ff == '0);
                  phase_in = (phase_inc >= {1'b0, period_ff}) ? '0 : phase_inc[CW-1:0];
               end else begin
                  seen_in[pidx] = seen_next;
               end
            end
            default: ;
         endcase
      end

      // reload the credit table on a self_id or credit_max write
      if (reload) begin
         for (int m = 0; m < M; m++) begin
            credits_in[m] = (self_id_in == SW'(m)) ? '0 : credit_max_in;
         end
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_req_in   = s1_req_ff;
      if (req_tready) begin
         s1_valid_in = req_tvalid;
         s1_req_in   = '{func:            pcfc_pkg::func_type'(req_tuser),
                         needs_broadcast: req_tdata[0],
                         peer:            req_tdata[8:1],
                         status_ok:       req_tdata[9],
                         last_in_batch:   req_tlast};
      end
      rsp_valid_in = rsp_valid_ff;
      if (out_free) begin
         rsp_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         self_id_ff    <= pcfc_pkg::SELF_RESET;
         credit_max_ff <= pcfc_pkg::CMAX_RESET;
         cpm_ff        <= pcfc_pkg::CPM_RESET;
         period_ff     <= pcfc_pkg::PERIOD_RESET;
         phase_ff      <= '0;
         hold_ff       <= 1'b0;
         for (int m = 0; m < M; m++) begin
            seen_ff[m]    <= '0;
            credits_ff[m] <= (pcfc_pkg::SELF_RESET == SW'(m)) ? '0 : pcfc_pkg::CMAX_RESET;
         end
      end else begin
         s1_valid_ff   <= s1_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         self_id_ff    <= self_id_in;
         credit_max_ff <= credit_max_in;
         cpm_ff        <= cpm_in;
         period_ff     <= period_in;
         phase_ff      <= phase_in;
         hold_ff       <= hold_in;
         seen_ff       <= seen_in;
         credits_ff    <= credits_in;
      end
      s1_req_ff <= s1_req_in;
      rsp_ff    <= rsp_in;
   end

`ifndef NO_ASSERTIONS
   a_grant_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_ff.granted && rsp_ff.stalled))
      else $error("grant and stall on one request");

   a_signal_send: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_ff.credit_signaled |-> rsp_ff.credit_send)
      else $error("signaled flag without a credit return");

   a_self_empty: assert property (@(posedge clock) disable iff (reset)
      self_id_ff < SW'(M) |-> credits_ff[self_id_ff[IW-1:0]] == '0)
      else $error("self holds credits");

   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("request taken with both stages full");

   a_grant_clear_hold: assert property (@(posedge clock) disable iff (reset)
      s1_go && s1_req_ff.func == pcfc_pkg::FUNC_BCAST && s1_req_ff.last_in_batch
      |=> !hold_ff)
      else $error("batch end left hold set");
`endif

endmodule

`default_nettype wire

>>> tb/sv/tb_peer_credit_flow_control.sv
// Self-checking testbench for peer_credit_flow_control: directed and random requests,
// with a credit ledger that predicts every response and random stalls on both sides.
// Depends on pcfc_pkg and the peer_credit_flow_control RTL.
module tb_peer_credit_flow_control;

   // Mirrors the credit table, seen counters and batch hold; queues due responses.
   class credit_ledger;
      int                self_id;
      int                credit_max;
      int                credits_per_msg;
      int                signal_period;
      int                credits [pcfc_pkg::MACHINES];
      int                seen [pcfc_pkg::MACHINES];
      int                signal_phase;
      bit                batch_hold;
      pcfc_pkg::rsp_type due_responses [$];
      int                mismatches;

      function new();
         self_id         = int'(pcfc_pkg::SELF_RESET);
         credit_max      = int'(pcfc_pkg::CMAX_RESET);
         credits_per_msg = int'(pcfc_pkg::CPM_RESET);
         signal_period   = int'(pcfc_pkg::PERIOD_RESET);
         signal_phase    = 0;
         batch_hold      = 1'b0;
         mismatches      = 0;
         foreach (seen[m]) seen[m] = 0;
         refill();
      endfunction

      function void refill();
         foreach (credits[m]) credits[m] = (m == self_id) ? 0 : credit_max;
      endfunction

      function void write_register(pcfc_pkg::csr_index_type idx,
                                   logic [pcfc_pkg::CSR_W-1:0] value);
         case (idx)
            pcfc_pkg::CSR_SELF_ID: begin
               self_id = int'(value[pcfc_pkg::SELF_W-1:0]);
               refill();
            end
            pcfc_pkg::CSR_CREDIT_MAX: begin
               credit_max = int'(value);
               refill();
            end
            pcfc_pkg::CSR_CREDITS_PM: credits_per_msg = int'(value);
            pcfc_pkg::CSR_SIG_PERIOD: signal_period = int'(value);
            default: ;
         endcase
      endfunction

      function void note_request(pcfc_pkg::req_type r);
         pcfc_pkg::rsp_type exp;
         bit                all_credited;
         int                p;
         int                sum;
         exp = '0;
         p   = int'(r.peer);
         if (r.func == pcfc_pkg::FUNC_BCAST) begin
            if (r.needs_broadcast) begin
               all_credited = 1'b1;
               foreach (credits[m])
                  if (m != self_id && credits[m] == 0) all_credited = 1'b0;
               if (!batch_hold && all_credited) begin
                  foreach (credits[m])
                     if (m != self_id) credits[m] = credits[m] - 1;
                  exp.granted = 1'b1;
               end else begin
                  exp.stalled = 1'b1;
                  batch_hold  = 1'b1;
               end
            end
            if (r.last_in_batch) batch_hold = 1'b0;
         end else if (r.func == pcfc_pkg::FUNC_CREDIT || r.func == pcfc_pkg::FUNC_COH) begin
            if (!r.status_ok || p >= pcfc_pkg::MACHINES || p == self_id) begin
               exp.ignored = 1'b1;
            end else if (r.func == pcfc_pkg::FUNC_CREDIT) begin
               sum = credits[p] + credits_per_msg;
               credits[p] = (sum > credit_max) ? credit_max : sum;
            end else begin
               sum = (seen[p] >= 255) ? 255 : seen[p] + 1;
               if (sum >= credits_per_msg) begin
                  sum                 = 0;
                  exp.credit_send     = 1'b1;
                  exp.credit_target   = 5'(p);
                  exp.credit_signaled = (signal_phase == 0);
                  signal_phase = (signal_phase + 1 >= signal_period) ? 0 : signal_phase + 1;
               end
               seen[p] = sum;
            end
         end
         due_responses.push_back(exp);
      endfunction

      function void check_field(string name, int want, int got);
         if (want != got) begin
            mismatches++;
            $error("%s: expected %0d, actual %0d", name, want, got);
         end
      endfunction

      function void check_response(pcfc_pkg::rsp_type got);
         pcfc_pkg::rsp_type exp;
         if (due_responses.size() == 0) begin
            mismatches++;
            $error("response %h arrived with no request outstanding", got);
            return;
         end
         exp = due_responses.pop_front();
         check_field("granted", int'(exp.granted), int'(got.granted));
         check_field("stalled", int'(exp.stalled), int'(got.stalled));
         check_field("credit_send", int'(exp.credit_send), int'(got.credit_send));
         check_field("credit_target", int'(exp.credit_target), int'(got.credit_target));
         check_field("credit_signaled", int'(exp.credit_signaled),
                     int'(got.credit_signaled));
         check_field("ignored", int'(exp.ignored), int'(got.ignored));
      endfunction
   endclass

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_tvalid = 1'b0;
   logic                        req_tready;
   logic [15:0]                 req_tdata;
   logic [1:0]                  req_tuser;
   logic                        req_tlast;
   logic                        rsp_tvalid;
   logic                        rsp_tready = 1'b0;
   logic [15:0]                 rsp_tdata;
   logic                        csr_we = 1'b0;
   logic [pcfc_pkg::CSR_AW-1:0] csr_addr = '0;
   logic [pcfc_pkg::CSR_W-1:0]  csr_wdata = '0;

   pcfc_pkg::req_type offered = '0;
   credit_ledger      ledger;
   bit                steady = 1'b0;
   bit                hold_off_pending = 1'b0;

   // [0] needs_broadcast, [8:1] peer, [9] status_ok
   assign req_tdata = {6'b0, offered.status_ok, offered.peer, offered.needs_broadcast};
   assign req_tuser = offered.func;
   assign req_tlast = offered.last_in_batch;

   peer_credit_flow_control dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) ledger.note_request(offered);
         if (rsp_tvalid && rsp_tready)
            ledger.check_response(pcfc_pkg::rsp_type'(rsp_tdata[9:0]));
      end
   end

   // Response side: random back-pressure, or one long hold-off when asked
   initial begin
      forever begin
         @(negedge clock);
         if (hold_off_pending) begin
            hold_off_pending = 1'b0;
            rsp_tready = 1'b0;
            repeat (120) @(negedge clock);
         end else begin
            rsp_tready = steady || ($urandom_range(0, 99) >= 29);
         end
      end
   end

   initial begin
      #2_000_000;
      $display("simulation failed");
      $finish;
   end

   task automatic offer(pcfc_pkg::req_type r);
      @(negedge clock);
      while (!steady && $urandom_range(0, 99) < 29) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      offered    = r;
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic offer_fields(pcfc_pkg::func_type f, bit needs, logic [7:0] peer, bit ok,
                               bit last);
      pcfc_pkg::req_type r;
      r.func            = f;
      r.needs_broadcast = needs;
      r.peer            = peer;
      r.status_ok       = ok;
      r.last_in_batch   = last;
      offer(r);
   endtask

   // Drop valid and hold until every outstanding request has its response
   task automatic drain();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (ledger.due_responses.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(pcfc_pkg::csr_index_type idx,
                            logic [pcfc_pkg::CSR_W-1:0] value);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_addr  = idx;
      csr_wdata = value;
      @(posedge clock);
      ledger.write_register(idx, value);
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic configure(logic [7:0] self_val, logic [7:0] cmax, logic [7:0] cpm,
                            logic [7:0] period);
      drain();
      write_csr(pcfc_pkg::CSR_SELF_ID, self_val);
      write_csr(pcfc_pkg::CSR_CREDIT_MAX, cmax);
      write_csr(pcfc_pkg::CSR_CREDITS_PM, cpm);
      write_csr(pcfc_pkg::CSR_SIG_PERIOD, period);
   endtask

   task automatic directed_requests();
      offer_fields(pcfc_pkg::FUNC_BCAST, 1'b1, 8'd0, 1'b0, 1'b0);
      offer_fields(pcfc_pkg::FUNC_BCAST, 1'b0, 8'd255, 1'b1, 1'b0);
      offer_fields(pcfc_pkg::FUNC_NONE, 1'b1, 8'd255, 1'b1, 1'b1);
      offer_fields(pcfc_pkg::FUNC_CREDIT, 1'b0, 8'd3, 1'b1, 1'b0);
      offer_fields(pcfc_pkg::FUNC_CREDIT, 1'b0, 8'd0, 1'b1, 1'b0);
      offer_fields(pcfc_pkg::FUNC_CREDIT, 1'b0, 8'd200, 1'b1, 1'b0);
      offer_fields(pcfc_pkg::FUNC_COH, 1'b0, 8'd5, 1'b0, 1'b0);
      offer_fields(pcfc_pkg::FUNC_COH, 1'b1, 8'd7, 1'b1, 1'b1);
      // one message per credit return, every return signalled
      configure(8'd0, 8'd30, 8'd1, 8'd1);
      offer_fields(pcfc_pkg::FUNC_COH, 1'b0, 8'd2, 1'b1, 1'b0);
      offer_fields(pcfc_pkg::FUNC_COH, 1'b0, 8'd2, 1'b1, 1'b0);
      offer_fields(pcfc_pkg::FUNC_COH, 1'b0, 8'd1, 1'b1, 1'b0);
      // self beyond range: all machines are peers, a single credit each
      configure(8'hFF, 8'd1, 8'd1, 8'd1);
      offer_fields(pcfc_pkg::FUNC_BCAST, 1'b1, 8'd0, 1'b1, 1'b0);
      offer_fields(pcfc_pkg::FUNC_BCAST, 1'b1, 8'd0, 1'b1, 1'b0);
      offer_fields(pcfc_pkg::FUNC_BCAST, 1'b0, 8'd0, 1'b1, 1'b0);
      offer_fields(pcfc_pkg::FUNC_CREDIT, 1'b0, 8'd0, 1'b1, 1'b0);
      offer_fields(pcfc_pkg::FUNC_BCAST, 1'b1, 8'd0, 1'b1, 1'b1);
      // zero cap, zero threshold, zero period
      configure(8'd6, 8'd0, 8'd0, 8'd0);
      offer_fields(pcfc_pkg::FUNC_BCAST, 1'b1, 8'd0, 1'b1, 1'b0);
      offer_fields(pcfc_pkg::FUNC_BCAST, 1'b1, 8'd0, 1'b1, 1'b1);
      offer_fields(pcfc_pkg::FUNC_COH, 1'b0, 8'd4, 1'b1, 1'b0);
      offer_fields(pcfc_pkg::FUNC_COH, 1'b0, 8'd4, 1'b1, 1'b0);
      offer_fields(pcfc_pkg::FUNC_COH, 1'b0, 8'd6, 1'b1, 1'b0);
      offer_fields(pcfc_pkg::FUNC_CREDIT, 1'b0, 8'd8, 1'b1, 1'b0);
   endtask

   // Mostly broadcast batches and good arrivals from real peers, some noise
   task automatic random_requests(int count, int bcast_pct);
      pcfc_pkg::req_type r;
      int                batch_left;
      int                roll;
      batch_left = $urandom_range(1, 8);
      repeat (count) begin
         roll              = $urandom_range(0, 99);
         r.peer            = 8'($urandom);
         r.status_ok       = 1'($urandom);
         r.needs_broadcast = 1'($urandom);
         r.last_in_batch   = 1'($urandom);
         if (roll < bcast_pct) begin
            r.func            = pcfc_pkg::FUNC_BCAST;
            r.needs_broadcast = ($urandom_range(0, 99) < 85);
            batch_left--;
            r.last_in_batch = (batch_left == 0);
            if (batch_left == 0) batch_left = $urandom_range(1, 8);
         end else if (roll < 96) begin
            if ($urandom_range(0, 1) == 0) r.func = pcfc_pkg::FUNC_CREDIT;
            else r.func = pcfc_pkg::FUNC_COH;
            if ($urandom_range(0, 99) < 88)
               r.peer = 8'($urandom_range(0, pcfc_pkg::MACHINES - 1));
            r.status_ok = ($urandom_range(0, 99) < 92);
         end else begin
            r.func = pcfc_pkg::FUNC_NONE;
         end
         offer(r);
      end
   endtask

   function automatic logic [7:0] pick_count();
      if ($urandom_range(0, 99) < 70) return 8'($urandom_range(1, 12));
      return 8'($urandom_range(0, 255));
   endfunction

   initial begin
      ledger = new();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      directed_requests();

      configure(8'd3, 8'd4, 8'd2, 8'd3);
      random_requests(150, 40);

      steady = 1'b1;
      configure(8'hFF, 8'd255, 8'd255, 8'd255);
      random_requests(100, 45);
      steady = 1'b0;

      // long response hold-off while requests keep coming
      configure(8'd7, 8'd1, 8'd1, 8'd2);
      hold_off_pending = 1'b1;
      random_requests(150, 35);

      configure(8'd5, 8'd0, 8'd0, 8'd0);
      random_requests(60, 40);

      configure(8'd2, 8'd3, 8'd3, 8'd1);
      random_requests(120, 40);

      repeat (3) begin
         configure(8'($urandom), pick_count(), pick_count(), pick_count());
         random_requests(120, $urandom_range(25, 50));
      end

      drain();
      repeat (6) @(posedge clock);
      if (ledger.mismatches == 0 && ledger.due_responses.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

>>> peer_credit_flow_control.f
rtl/core/pcfc_pkg.sv
rtl/core/peer_credit_flow_control.sv
tb/sv/tb_peer_credit_flow_control.sv
